[design/rwhe_pkg.sv]
// Package for the running wave height estimator: widths, constants and the
// queue entry type shared by the front end and the arithmetic back end.
// No dependencies.
package rwhe_pkg;

	localparam int CELLS    = 4096;
	localparam int CELL_W   = 12;
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int ELEV_W   = 16;
	localparam int STEP_W   = 20;
	localparam int TIME_W   = 48;
	localparam int START_W  = 40;
	localparam int CNT_W    = 32;
	localparam int SUM_W    = 64;
	localparam int WAVE_W   = 16;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

	// job handed from the front end to the back end
	typedef struct packed {
		logic [CELL_W-1:0] cidx;
		logic              avg;
		logic [SUM_W-1:0]  ws;
		logic [SUM_W-1:0]  s2;
		logic [TIME_W-1:0] t;
		logic [CNT_W-1:0]  n;
	} job_t;

endpackage

[design/rwhe_front.sv]
// Front end: timers, per-cell sum stores (cleared after reset) and job build.
// Depends on rwhe_pkg.
module rwhe_front import rwhe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [START_W-1:0]  start_time,
	input  logic                in_take,
	input  logic [CELL_W-1:0]   cell_req,
	input  logic [ELEV_W-1:0]   elevation,
	input  logic                step_start,
	input  logic [STEP_W-1:0]   step_length,
	output logic                busy,
	output logic                job_valid,
	output job_t                job,
	input  logic                job_ready
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]        state_q;
	logic [ADDR_W:0]   clr_q;
	logic [TIME_W-1:0] wall_q, avgt_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [STEP_W-1:0] held_q;
	logic [CELL_W-1:0] cell_q;
	logic [ELEV_W-1:0] elev_q;
	logic              upd_q;
	logic [SUM_W-1:0]  ws_mem [CELLS];
	logic [SUM_W-1:0]  s2_mem [CELLS];
	logic [SUM_W-1:0]  ws_rd_q, s2_rd_q;
	logic [SUM_W-1:0]  ws_new, s2_new;
	logic [TIME_W:0]   wall_sum, avgt_sum;
	logic [TIME_W-1:0] wall_nx;
	logic signed [SUM_W-1:0] prod, ws_old, ws_add;
	logic [SUM_W-1:0]  sq;
	logic [SUM_W:0]    s2_add;
	job_t              job_q;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;

	assign wall_sum = {1'b0, wall_q} + {{(TIME_W+1-STEP_W){1'b0}}, step_length};
	assign wall_nx  = wall_sum[TIME_W] ? TIME_MAX : wall_sum[TIME_W-1:0];
	assign avgt_sum = {1'b0, avgt_q} + {{(TIME_W+1-STEP_W){1'b0}}, step_length};

	assign prod   = SUM_W'($signed(elev_q)) * $signed({1'b0, held_q});
	assign ws_old = $signed(ws_rd_q);
	assign ws_add = ws_old + prod;
	assign sq     = SUM_W'($unsigned(SUM_W'($signed(elev_q)) * SUM_W'($signed(elev_q))));
	assign s2_add = {1'b0, s2_rd_q} + {1'b0, sq};

	always_comb begin
		if (!prod[SUM_W-1] && !ws_old[SUM_W-1] && ws_add[SUM_W-1])
			ws_new = {1'b0, {(SUM_W-1){1'b1}}};
		else if (prod[SUM_W-1] && ws_old[SUM_W-1] && !ws_add[SUM_W-1])
			ws_new = {1'b1, {(SUM_W-1){1'b0}}};
		else
			ws_new = ws_add;
		s2_new = s2_add[SUM_W] ? {SUM_W{1'b1}} : s2_add[SUM_W-1:0];
	end

	assign wr_en   = (state_q == ST_CLEAR) || (state_q == ST_READ && upd_q);
	assign wr_addr = (state_q == ST_CLEAR) ? clr_q[ADDR_W-1:0] : cell_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ws_mem[wr_addr] <= (state_q == ST_CLEAR) ? '0 : ws_new;
			s2_mem[wr_addr] <= (state_q == ST_CLEAR) ? '0 : s2_new;
		end
		if (in_take) begin
			ws_rd_q <= ws_mem[cell_req[ADDR_W-1:0]];
			s2_rd_q <= s2_mem[cell_req[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			wall_q  <= '0;
			avgt_q  <= '0;
			cnt_q   <= '0;
			held_q  <= '0;
			cell_q  <= '0;
			elev_q  <= '0;
			upd_q   <= 1'b0;
			job_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (ADDR_W+1)'(CELLS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_take) begin
						cell_q  <= cell_req;
						elev_q  <= elevation;
						state_q <= ST_READ;
						if (step_start) begin
							held_q <= step_length;
							wall_q <= wall_nx;
							if (wall_nx > {{(TIME_W-START_W){1'b0}}, start_time}) begin
								avgt_q <= avgt_sum[TIME_W] ? TIME_MAX : avgt_sum[TIME_W-1:0];
								if (cnt_q != CNT_MAX)
									cnt_q <= cnt_q + 1'b1;
							end
							upd_q <= (wall_nx > {{(TIME_W-START_W){1'b0}}, start_time})
								&& ({20'd0, cell_req} < 32'(CELLS));
						end else begin
							upd_q <= (wall_q > {{(TIME_W-START_W){1'b0}}, start_time})
								&& ({20'd0, cell_req} < 32'(CELLS));
						end
					end
				end
				ST_READ: begin
					job_q.cidx <= cell_q;
					job_q.avg  <= upd_q;
					job_q.ws   <= ws_new;
					job_q.s2   <= s2_new;
					job_q.t    <= avgt_q;
					job_q.n    <= cnt_q;
					state_q    <= ST_OUT;
				end
				ST_OUT: begin
					if (job_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = state_q != ST_IDLE;
	assign job_valid = state_q == ST_OUT;
	assign job       = job_q;

endmodule

[design/rwhe_queue.sv]
// Two-entry queue between the front end and the back end.
// Depends on rwhe_pkg.
module rwhe_queue import rwhe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_data
);

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= ~wp_q;
			if (rd)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

[design/rwhe_back.sv]
// Back end: mean, variance and square root by one shared bit-serial
// divider/root sequencer, result register. Depends on rwhe_pkg.
module rwhe_back import rwhe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  job_t               job,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [CELL_W-1:0]  res_cell,
	output logic [WAVE_W-1:0]  res_wave,
	output logic               res_avg
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MDIV = 3'd1;
	localparam logic [2:0] B_MSQ  = 3'd2;
	localparam logic [2:0] B_MUL  = 3'd3;
	localparam logic [2:0] B_VDIV = 3'd4;
	localparam logic [2:0] B_ROOT = 3'd5;
	localparam logic [2:0] B_DONE = 3'd6;

	logic [2:0]        st_q;
	logic [6:0]        it_q;
	job_t              j_q;
	// long division: dividend shifts in from num_q, remainder rem_q
	logic [SUM_W+16-1:0] num_q;
	logic [SUM_W:0]      rem_q;
	logic [SUM_W-1:0]    quo_q;
	logic [SUM_W-1:0]    den_q;
	logic [31:0]         m_q;
	logic [SUM_W-1:0]    m2_q;
	logic [SUM_W-1:0]    hi_q, lo_q;
	logic [31:0]         v_q, res_q, bit_q;
	logic [WAVE_W-1:0]   wave_q;
	logic                out_v_q;
	logic [SUM_W:0]      rem_sh, rem_sub;
	logic [SUM_W-1:0]    mag;
	logic [SUM_W:0]      p_sum;
	logic [SUM_W-1:0]    p;
	logic [31:0]         rb;

	assign rem_sh  = {rem_q[SUM_W-1:0], num_q[SUM_W+16-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign mag     = j_q.ws[SUM_W-1] ? (~j_q.ws + 1'b1) : j_q.ws;
	assign p_sum   = {1'b0, hi_q} + {1'b0, lo_q};
	assign p       = p_sum[SUM_W] ? {SUM_W{1'b1}} : p_sum[SUM_W-1:0];
	assign rb      = res_q + bit_q;

	assign job_ready = st_q == B_IDLE;
	assign res_valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= B_IDLE;
			it_q     <= '0;
			out_v_q  <= 1'b0;
			j_q      <= '0;
			num_q    <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			den_q    <= '0;
			m_q      <= '0;
			m2_q     <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
			v_q      <= '0;
			res_q    <= '0;
			bit_q    <= '0;
			wave_q   <= '0;
			res_cell <= '0;
			res_wave <= '0;
			res_avg  <= 1'b0;
		end else begin
			if (out_v_q && res_ready && st_q != B_DONE)
				out_v_q <= 1'b0;
			case (st_q)
				B_IDLE: begin
					if (job_valid) begin
						j_q    <= job;
						wave_q <= '0;
						if (!job.avg || job.n <= 32'd1) begin
							st_q <= B_DONE;
						end else if (job.t == '0) begin
							m_q  <= '0;
							it_q <= '0;
							st_q <= B_MSQ;
						end else begin
							st_q <= B_MDIV;
							it_q <= '0;
							rem_q <= '0;
							quo_q <= '0;
							den_q <= {{(SUM_W-TIME_W){1'b0}}, job.t};
							num_q <= '0;
						end
					end
				end
				B_MDIV: begin
					// 80 bit dividend |ws|<<16 over t
					if (!(it_q == 7'd0 && num_q == '0 && mag != '0 && rem_q == '0)) begin
						num_q <= {num_q[SUM_W+16-2:0], 1'b0};
						if (!rem_sub[SUM_W]) begin
							rem_q <= rem_sub;
							quo_q <= {quo_q[SUM_W-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[SUM_W-2:0], 1'b0};
						end
						if (quo_q[SUM_W-1:32] != '0 || it_q == 7'd79) begin
							st_q <= B_MSQ;
						end
						it_q <= it_q + 1'b1;
					end else begin
						num_q <= {mag, 16'd0};
						quo_q <= '0;
						it_q  <= 7'd0;
						// load step: mark started by forcing a zero quotient bit path
						rem_q <= '0;
					end
				end
				B_MSQ: begin
					if (st_q == B_MSQ && it_q != 7'd0 && (quo_q[SUM_W-1:32] != '0))
						m_q <= 32'hFFFF_FFFF;
					else if (it_q != 7'd0)
						m_q <= quo_q[31:0];
					it_q <= '0;
					st_q <= B_MUL;
				end
				B_MUL: begin
					if (it_q == 7'd0) begin
						m2_q <= {32'd0, m_q} * {32'd0, m_q};
						it_q <= 7'd1;
					end else if (it_q == 7'd1) begin
						hi_q <= {32'd0, m2_q[63:32]} * {32'd0, j_q.n};
						lo_q <= ({32'd0, m2_q[31:0]} * {32'd0, j_q.n}) >> 32;
						it_q <= 7'd2;
					end else begin
						if (j_q.s2 <= p) begin
							st_q <= B_DONE;
						end else begin
							num_q <= {j_q.s2 - p, 16'd0};
							den_q <= {32'd0, j_q.n - 32'd1};
							rem_q <= '0;
							quo_q <= '0;
							it_q  <= '0;
							st_q  <= B_VDIV;
						end
					end
				end
				B_VDIV: begin
					num_q <= {num_q[SUM_W+16-2:0], 1'b0};
					if (!rem_sub[SUM_W]) begin
						rem_q <= rem_sub;
						quo_q <= {quo_q[SUM_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[SUM_W-2:0], 1'b0};
					end
					if (it_q == 7'd63) begin
						st_q <= B_ROOT;
						it_q <= '0;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				B_ROOT: begin
					if (it_q == 7'd0) begin
						if (quo_q >= 64'd268435456) begin
							wave_q <= 16'hFFFF;
							st_q   <= B_DONE;
						end else begin
							v_q   <= {quo_q[27:0], 4'd0};
							res_q <= '0;
							bit_q <= 32'h4000_0000;
							it_q  <= 7'd1;
						end
					end else if (bit_q == '0) begin
						wave_q <= (res_q > 32'd65535) ? 16'hFFFF : res_q[15:0];
						st_q   <= B_DONE;
					end else begin
						if (v_q >= rb) begin
							v_q   <= v_q - rb;
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				B_DONE: begin
					if (!out_v_q || res_ready) begin
						res_cell <= j_q.cidx;
						res_wave <= wave_q;
						res_avg  <= j_q.avg;
						out_v_q  <= 1'b1;
						st_q     <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule

[design/running_wave_height_estimator.sv]
// Running significant wave height estimator, top level.
// Depends on rwhe_pkg, rwhe_front, rwhe_queue, rwhe_back.
//
// After reset the block clears its two 4096-entry sum stores, one entry a
// cycle (full held high); start_time may be written meanwhile.
// Each transfer is then read-modified-written by the front end and
// queued; the back end works each item through its shared bit-serial
// divider (mean, then variance) and square root, so a sustained rate is
// set by that sequencer. Results leave in input order.
module running_wave_height_estimator import rwhe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [START_W-1:0]  cfg_data,
	input  logic                push,
	output logic                full,
	input  logic [CELL_W-1:0]   cell_req,
	input  logic [ELEV_W-1:0]   elevation,
	input  logic                step_start,
	input  logic [STEP_W-1:0]   step_length,
	output logic                empty,
	input  logic                pop,
	output logic [CELL_W-1:0]   cell_out,
	output logic [WAVE_W-1:0]   wave_height,
	output logic                averaging
);

	logic [START_W-1:0] start_q;
	logic fe_busy, fe_v, fe_r, q_v, q_r, res_v, in_take;
	job_t fe_job, q_job;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			start_q <= '0;
		else if (cfg_valid)
			start_q <= cfg_data;
	end

	assign full    = fe_busy;
	assign in_take = push && !full;

	rwhe_front u_front (
		.clk, .arst_n, .start_time(start_q), .in_take,
		.cell_req, .elevation, .step_start, .step_length,
		.busy(fe_busy), .job_valid(fe_v), .job(fe_job), .job_ready(fe_r)
	);

	rwhe_queue u_queue (
		.clk, .arst_n, .wr_valid(fe_v), .wr_ready(fe_r), .wr_data(fe_job),
		.rd_valid(q_v), .rd_ready(q_r), .rd_data(q_job)
	);

	rwhe_back u_back (
		.clk, .arst_n, .job_valid(q_v), .job_ready(q_r), .job(q_job),
		.res_valid(res_v), .res_ready(pop),
		.res_cell(cell_out), .res_wave(wave_height), .res_avg(averaging)
	);

	assign empty = !res_v;

	a_wave_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !averaging) |-> (wave_height == '0))
		else $error("wave height set while not averaging");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(cell_out) && $stable(wave_height)))
		else $error("waiting result changed");
	a_no_take_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push && full) |=> $stable(start_q) || $past(cfg_valid))
		else $error("start time changed without a write");

endmodule

[dv/rwhe_checker.sv]
// Checker for the running wave height estimator: watches the config, input and
// result channels, predicts each result and compares it field by field.
// Depends on rwhe_pkg.
module rwhe_checker import rwhe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [START_W-1:0] cfg_data,
	input  logic               push,
	input  logic               full,
	input  logic [CELL_W-1:0]  cell_req,
	input  logic [ELEV_W-1:0]  elevation,
	input  logic               step_start,
	input  logic [STEP_W-1:0]  step_length,
	input  logic               empty,
	input  logic               pop,
	input  logic [CELL_W-1:0]  cell_out,
	input  logic [WAVE_W-1:0]  wave_height,
	input  logic               averaging,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		logic [CELL_W-1:0] cidx;
		logic [WAVE_W-1:0] wave;
		logic              avg;
	} height_t;

	height_t heights_due[$];

	logic [START_W-1:0] start_t;
	logic [TIME_W-1:0]  wall_t;
	logic [TIME_W-1:0]  avg_t;
	logic [CNT_W-1:0]   samples;
	logic [STEP_W-1:0]  held;
	longint             wsum [CELLS];
	logic [SUM_W-1:0]   sqsum [CELLS];

	initial errors = 0;
	initial pending = 0;

	task automatic report(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		errors++;
	endtask

	function automatic logic [31:0] int_root(input logic [31:0] v);
		logic [31:0] r;
		logic [31:0] t;
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			t = r | (32'd1 << b);
			if (64'(t) * 64'(t) <= 64'(v)) r = t;
		end
		return r;
	endfunction

	function automatic logic [WAVE_W-1:0] height_of(input longint ws, input logic [63:0] s2,
			input logic [TIME_W-1:0] t, input logic [CNT_W-1:0] n);
		logic [127:0] mag;
		logic [127:0] m;
		logic [127:0] p;
		logic [63:0]  v;
		logic [31:0]  r;
		if (n <= 1) return 0;
		m = 0;
		if (t != 0) begin
			mag = (ws < 0) ? 128'($unsigned(-ws)) : 128'($unsigned(ws));
			m = (mag << 16) / 128'(t);
			if (m > 128'hFFFF_FFFF) m = 128'hFFFF_FFFF;
		end
		p = (m * m * 128'(n)) >> 32;
		if (p > 128'hFFFF_FFFF_FFFF_FFFF) p = 128'hFFFF_FFFF_FFFF_FFFF;
		if (128'(s2) <= p) return 0;
		v = (s2 - p[63:0]) / 64'(n - 1);
		if (v >= 64'd1 << 28) return 16'hFFFF;
		r = int_root(v[31:0] * 32'd16);
		return r[15:0];
	endfunction

	task automatic take_sample();
		longint      e;
		longint      prod;
		longint      ws;
		logic [64:0] sq;
		height_t     h;
		logic [48:0] nt;
		e = longint'($signed(elevation));
		if (step_start) begin
			held = step_length;
			nt = 49'(wall_t) + 49'(held);
			wall_t = nt > 49'(TIME_MAX) ? TIME_MAX : nt[47:0];
			if (wall_t > 48'(start_t)) begin
				nt = 49'(avg_t) + 49'(held);
				avg_t = nt > 49'(TIME_MAX) ? TIME_MAX : nt[47:0];
				if (samples != CNT_MAX) samples++;
			end
		end
		h.cidx = cell_req;
		h.wave = 0;
		h.avg  = 0;
		if (wall_t > 48'(start_t)) begin
			prod = e * longint'(held);
			ws = wsum[cell_req];
			if (prod > 0 && ws > 64'sh7FFF_FFFF_FFFF_FFFF - prod)
				ws = 64'sh7FFF_FFFF_FFFF_FFFF;
			else if (prod < 0 && ws < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - prod)
				ws = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
			else
				ws += prod;
			wsum[cell_req] = ws;
			sq = 65'(sqsum[cell_req]) + 65'(e * e);
			sqsum[cell_req] = sq[64] ? '1 : sq[63:0];
			h.wave = height_of(ws, sqsum[cell_req], avg_t, samples);
			h.avg = 1;
		end
		heights_due.push_back(h);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_t = 0;
			wall_t = 0;
			avg_t = 0;
			samples = 0;
			held = 0;
			for (int i = 0; i < CELLS; i++) begin
				wsum[i] = 0;
				sqsum[i] = 0;
			end
			heights_due.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) start_t = cfg_data;
			if (pop && !empty) begin
				if (heights_due.size() == 0) begin
					report($sformatf("result for cell %0d with none expected", cell_out));
				end else begin
					height_t h;
					h = heights_due.pop_front();
					if (cell_out !== h.cidx)
						report($sformatf("cell_out %0d, expected %0d", cell_out, h.cidx));
					if (wave_height !== h.wave)
						report($sformatf("cell %0d wave_height %0d, expected %0d",
							h.cidx, wave_height, h.wave));
					if (averaging !== h.avg)
						report($sformatf("cell %0d averaging %0b, expected %0b",
							h.cidx, averaging, h.avg));
				end
			end
			if (push && !full) take_sample();
			pending = heights_due.size();
		end
	end

endmodule

[dv/tb_running_wave_height_estimator.sv]
// Testbench top for the running wave height estimator: drives config, samples
// and result pops, and gives the verdict. Depends on rwhe_pkg, rwhe_checker
// and the block itself.
module tb_running_wave_height_estimator;
	import rwhe_pkg::*;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [START_W-1:0] cfg_data = 0;
	logic               push = 0;
	logic               full;
	logic [CELL_W-1:0]  cell_req = 0;
	logic [ELEV_W-1:0]  elevation = 0;
	logic               step_start = 0;
	logic [STEP_W-1:0]  step_length = 0;
	logic               empty;
	logic               pop = 0;
	logic [CELL_W-1:0]  cell_out;
	logic [WAVE_W-1:0]  wave_height;
	logic               averaging;
	int                 errors;
	int                 pending;
	bit                 calm = 0;
	int                 sent = 0;

	running_wave_height_estimator DUT (.*);

	rwhe_checker u_checker (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) pop <= calm || ($urandom_range(99) >= 7);

	task automatic write_start(input logic [START_W-1:0] v);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send(input logic [CELL_W-1:0] c, input logic [ELEV_W-1:0] e,
			input logic s, input logic [STEP_W-1:0] l);
		if (!calm && $urandom_range(99) < 7) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		cell_req <= c;
		elevation <= e;
		step_start <= s;
		step_length <= l;
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
	endtask

	function automatic logic [ELEV_W-1:0] pick_elev();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(4000)) - 2000);
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] pick_step();
		case ($urandom_range(9))
			0: return 0;
			1: return 20'hFFFFF;
			2: return 20'($urandom);
			default: return 20'($urandom_range(70000, 1000));
		endcase
	endfunction

	initial begin
		#(4 * 3_000_000);
		$display("tb_running_wave_height_estimator: errors");
		$finish;
	end

	initial begin
		int k;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		write_start(40'hFF_FFFF_FFFF);
		send(0, 16'h7FFF, 1, 20'hFFFFF);
		send(4095, 16'h8000, 0, 0);
		send(7, 0, 1, 20'd65536);
		push <= 0;
		write_start(0);
		send(0, 16'h8000, 1, 20'hFFFFF);
		send(4095, 16'h7FFF, 0, 0);
		send(0, 16'h7FFF, 1, 0);
		send(4095, 16'h8000, 0, 20'hFFFFF);
		for (int i = 0; i < 12; i++)
			send(12'(i % 3), (i % 2) ? 16'h7FFF : 16'h8000, i % 3 == 0, 20'd65536);
		send(1, 0, 1, 20'd1);
		send(2, 16'd5, 0, 20'd0);
		push <= 0;
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) write_start({8'd0, 32'($urandom)});
			if (ph == 2) write_start(0);
			k = 0;
			while (k < 240) begin
				calm = (ph == 1);
				send($urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(15)),
					pick_elev(), 1, pick_step());
				k++;
				for (int j = $urandom_range(7); j > 0; j--) begin
					send($urandom_range(4) == 0 ? 12'($urandom) : 12'($urandom_range(15)),
						pick_elev(), $urandom_range(19) == 0, 20'($urandom));
					k++;
				end
			end
			calm = 0;
			push <= 0;
		end
		write_start(40'hFF_FFFF_FFFF);
		send(3, pick_elev(), 1, pick_step());
		send(4, pick_elev(), 0, 0);
		push <= 0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("tb_running_wave_height_estimator: clean");
		else
			$display("tb_running_wave_height_estimator: errors");
		$finish;
	end

endmodule
